// File: hdl/btas_pkg.sv
// ============================================================================
// btas_pkg: shared types, microcode and helper functions
// Holds the control word format, the microprogram ROM and the bit helpers
// used by the load/store-multiple address sequencer.
// ============================================================================
package btas_pkg;

    // Fixed field widths
    localparam int LIST_W = 16;
    localparam int ADDR_W = 32;
    localparam int REG_W  = 4;
    localparam int CNT_W  = 5;

    // Default parameter values
    localparam int REG_COUNT_DEF  = 16;
    localparam int WORD_BYTES_DEF = 4;

    // Microprogram geometry
    localparam int UCODE_DEPTH = 4;
    localparam int PC_W        = 2;

    // Step addresses
    localparam logic [PC_W-1:0] PC_SPAN = 2'd0;
    localparam logic [PC_W-1:0] PC_INIT = 2'd1;
    localparam logic [PC_W-1:0] PC_XFER = 2'd2;
    localparam logic [PC_W-1:0] PC_WB   = 2'd3;

    // Datapath operations
    typedef enum logic [1:0] {
        UOP_SPAN = 2'd0,
        UOP_INIT = 2'd1,
        UOP_XFER = 2'd2,
        UOP_WB   = 2'd3
    } t_uop;

    // Jump conditions
    typedef enum logic [1:0] {
        COND_NONE  = 2'd0,
        COND_EMPTY = 2'd1,
        COND_MORE  = 2'd2
    } t_cond;

    typedef struct packed {
        t_uop             uop;
        t_cond            cond;
        logic [PC_W-1:0]  target;
        logic             done;
    } t_uword;

    // Sequencer to datapath
    typedef struct packed {
        logic en;
        t_uop uop;
    } t_ctrl;

    // Datapath to sequencer
    typedef struct packed {
        logic empty;
        logic more;
    } t_status;

    // Microprogram ROM
    function automatic t_uword ucode_word(input logic [PC_W-1:0] pc);
        t_uword w;
        unique case (pc)
            PC_SPAN: w = '{uop: UOP_SPAN, cond: COND_NONE,  target: PC_INIT, done: 1'b0};
            PC_INIT: w = '{uop: UOP_INIT, cond: COND_EMPTY, target: PC_WB,   done: 1'b0};
            PC_XFER: w = '{uop: UOP_XFER, cond: COND_MORE,  target: PC_XFER, done: 1'b0};
            PC_WB:   w = '{uop: UOP_WB,   cond: COND_NONE,  target: PC_SPAN, done: 1'b1};
        endcase
        return w;
    endfunction

    // Count set bits of a register list
    function automatic logic [CNT_W-1:0] pop_count(input logic [LIST_W-1:0] v);
        logic [CNT_W-1:0] c;
        c = '0;
        for (int i = 0; i < LIST_W; i++) begin
            c = c + CNT_W'(v[i]);
        end
        return c;
    endfunction

    // Index of lowest set bit
    function automatic logic [REG_W-1:0] lowest_set(input logic [LIST_W-1:0] v);
        logic [REG_W-1:0] idx;
        idx = '0;
        for (int i = LIST_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = REG_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// File: hdl/btas_sequencer.sv
// ============================================================================
// btas_sequencer: microprogram step counter
// Walks the control ROM one step per cycle, taking conditional jumps on
// datapath status, and raises busy for the length of one request.
// ============================================================================
module btas_sequencer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  btas_pkg::t_status i_status,
    output btas_pkg::t_ctrl   o_ctrl,
    output logic              o_busy
);

    logic [btas_pkg::PC_W-1:0] r_pc;
    logic [btas_pkg::PC_W-1:0] n_pc;
    logic                      r_busy;
    logic                      n_busy;
    btas_pkg::t_uword          word;
    logic                      jump;

    // Fetch the control word and pick the next step
    always_comb begin
        word = btas_pkg::ucode_word(r_pc);
        unique case (word.cond)
            btas_pkg::COND_EMPTY: jump = i_status.empty;
            btas_pkg::COND_MORE:  jump = i_status.more;
            default:              jump = 1'b0;
        endcase

        n_pc   = r_pc;
        n_busy = r_busy;
        if (!r_busy) begin
            n_pc = btas_pkg::PC_SPAN;
            if (i_accept) begin
                n_busy = 1'b1;
            end
        end else if (word.done) begin
            n_busy = 1'b0;
            n_pc   = btas_pkg::PC_SPAN;
        end else if (jump) begin
            n_pc = word.target;
        end else begin
            n_pc = r_pc + 1'b1;
        end

        o_ctrl.en  = r_busy;
        o_ctrl.uop = word.uop;
    end

    // Hold step counter and busy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= btas_pkg::PC_SPAN;
            r_busy <= 1'b0;
        end else begin
            r_pc   <= n_pc;
            r_busy <= n_busy;
        end
    end

    assign o_busy = r_busy;

    a_start_at_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |=> r_busy && r_pc == btas_pkg::PC_SPAN)
        else $error("sequencer did not enter the program at its first step");

    a_xfer_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_pc == btas_pkg::PC_XFER |-> !i_status.empty)
        else $error("transfer step entered with an empty list");

endmodule

// File: hdl/btas_datapath.sv
// ============================================================================
// btas_datapath: request registers, address adders and result register
// Latches one request, computes span and start address, and emits one
// transfer beat per set list bit plus an optional writeback beat.
// ============================================================================
module btas_datapath #(
    parameter int REG_COUNT  = btas_pkg::REG_COUNT_DEF,
    parameter int WORD_BYTES = btas_pkg::WORD_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [btas_pkg::LIST_W-1:0]  i_register_list,
    input  logic [btas_pkg::ADDR_W-1:0]  i_base_value,
    input  logic [btas_pkg::REG_W-1:0]   i_base_register,
    input  logic                         i_pre_index,
    input  logic                         i_ascending,
    input  logic                         i_user_request,
    input  logic                         i_write_back,
    input  logic                         i_is_load,
    input  btas_pkg::t_ctrl              i_ctrl,
    output btas_pkg::t_status            o_status,
    output logic                         o_valid,
    output logic                         o_kind,
    output logic [btas_pkg::REG_W-1:0]   o_register_index,
    output logic [btas_pkg::ADDR_W-1:0]  o_address,
    output logic                         o_load,
    output logic                         o_use_user_bank,
    output logic                         o_mode_flag,
    output logic                         o_last
);

    localparam int SPAN_W = $clog2(REG_COUNT * WORD_BYTES + 1);
    localparam logic [btas_pkg::LIST_W-1:0] LIST_MASK =
        btas_pkg::LIST_W'((64'd1 << REG_COUNT) - 64'd1);
    localparam logic [btas_pkg::ADDR_W-1:0] STEP = btas_pkg::ADDR_W'(WORD_BYTES);

    // Request registers
    logic [btas_pkg::LIST_W-1:0] r_list;
    logic [btas_pkg::ADDR_W-1:0] r_base;
    logic [btas_pkg::REG_W-1:0]  r_base_reg;
    logic                        r_step_first;
    logic                        r_up;
    logic                        r_user_bank;
    logic                        r_mode;
    logic                        r_wb;
    logic                        r_ld;
    logic [SPAN_W-1:0]           r_span;
    logic [btas_pkg::ADDR_W-1:0] r_addr;
    logic [btas_pkg::ADDR_W-1:0] r_new_base;

    logic [btas_pkg::LIST_W-1:0] rest;
    logic [btas_pkg::ADDR_W-1:0] span_ext;

    // Remaining list after the current transfer
    always_comb begin
        rest            = r_list & (r_list - 1'b1);
        o_status.empty  = (r_list == '0);
        o_status.more   = |rest;
        span_ext        = btas_pkg::ADDR_W'(r_span);
    end

    // Latch request and run the current micro-op
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_list       <= i_register_list & LIST_MASK;
            r_base       <= i_base_value;
            r_base_reg   <= i_base_register;
            r_step_first <= (i_pre_index == i_ascending);
            r_up         <= i_ascending;
            r_user_bank  <= i_user_request & ~i_register_list[btas_pkg::LIST_W-1];
            r_mode       <= i_user_request & i_is_load;
            r_wb         <= i_write_back;
            r_ld         <= i_is_load;
        end else if (i_ctrl.en) begin
            unique case (i_ctrl.uop)
                btas_pkg::UOP_SPAN: begin
                    r_span <= SPAN_W'(btas_pkg::pop_count(r_list)) * SPAN_W'(WORD_BYTES);
                end
                btas_pkg::UOP_INIT: begin
                    if (r_up) begin
                        r_addr     <= r_base;
                        r_new_base <= r_base + span_ext;
                    end else begin
                        r_addr     <= r_base - span_ext;
                        r_new_base <= r_base - span_ext;
                    end
                end
                btas_pkg::UOP_XFER: begin
                    r_list <= rest;
                    r_addr <= r_addr + STEP;
                end
                default: begin
                end
            endcase
        end
    end

    // Drive the result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_ctrl.en &&
                       (i_ctrl.uop == btas_pkg::UOP_XFER ||
                        (i_ctrl.uop == btas_pkg::UOP_WB && r_wb));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.uop == btas_pkg::UOP_XFER) begin
            o_kind           <= 1'b0;
            o_register_index <= btas_pkg::lowest_set(r_list);
            o_address        <= r_step_first ? r_addr + STEP : r_addr;
            o_load           <= r_ld;
            o_use_user_bank  <= r_user_bank;
            o_mode_flag      <= r_mode;
            o_last           <= ~(|rest) & ~r_wb;
        end else begin
            o_kind           <= 1'b1;
            o_register_index <= r_base_reg;
            o_address        <= r_new_base;
            o_load           <= 1'b0;
            o_use_user_bank  <= 1'b0;
            o_mode_flag      <= 1'b0;
            o_last           <= 1'b1;
        end
    end

    a_wb_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind |-> o_last)
        else $error("writeback beat not marked last");

    a_wb_only_when_asked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind |-> $past(r_wb))
        else $error("writeback beat without writeback request");

endmodule

// File: hdl/block_transfer_address_sequencer_unit.sv
// ============================================================================
// block_transfer_address_sequencer_unit: load/store-multiple address sequencer
// Top level joining the microcoded sequencer and its datapath.
// ============================================================================
// A request is taken when start is high and busy is low. The first beat
// comes after the span, start-address and first transfer steps, then one
// transfer beat per cycle, lowest register first, followed directly by the
// writeback beat if asked. Busy stays high while the four-step microprogram
// runs; its transfer step runs once per listed register, and no new request
// is taken until the last one is through. Beats are strobed by o_valid for
// one cycle each and cannot be held off: the receiver must take every beat
// as it comes. o_last marks the final beat of a request; a request with an
// empty list and no writeback yields no beat at all.
module block_transfer_address_sequencer_unit #(
    parameter int REG_COUNT  = btas_pkg::REG_COUNT_DEF,
    parameter int WORD_BYTES = btas_pkg::WORD_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [btas_pkg::LIST_W-1:0]  i_register_list,
    input  logic [btas_pkg::ADDR_W-1:0]  i_base_value,
    input  logic [btas_pkg::REG_W-1:0]   i_base_register,
    input  logic                         i_pre_index,
    input  logic                         i_ascending,
    input  logic                         i_user_request,
    input  logic                         i_write_back,
    input  logic                         i_is_load,
    output logic                         o_valid,
    output logic                         o_kind,
    output logic [btas_pkg::REG_W-1:0]   o_register_index,
    output logic [btas_pkg::ADDR_W-1:0]  o_address,
    output logic                         o_load,
    output logic                         o_use_user_bank,
    output logic                         o_mode_flag,
    output logic                         o_last
);

    logic              accept;
    btas_pkg::t_ctrl   ctrl;
    btas_pkg::t_status status;

    // Take a request beat when idle
    assign accept = start & ~busy;

    btas_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_status (status),
        .o_ctrl   (ctrl),
        .o_busy   (busy)
    );

    btas_datapath #(
        .REG_COUNT  (REG_COUNT),
        .WORD_BYTES (WORD_BYTES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_register_list  (i_register_list),
        .i_base_value     (i_base_value),
        .i_base_register  (i_base_register),
        .i_pre_index      (i_pre_index),
        .i_ascending      (i_ascending),
        .i_user_request   (i_user_request),
        .i_write_back     (i_write_back),
        .i_is_load        (i_is_load),
        .i_ctrl           (ctrl),
        .o_status         (status),
        .o_valid          (o_valid),
        .o_kind           (o_kind),
        .o_register_index (o_register_index),
        .o_address        (o_address),
        .o_load           (o_load),
        .o_use_user_bank  (o_use_user_bank),
        .o_mode_flag      (o_mode_flag),
        .o_last           (o_last)
    );

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |=> !o_valid)
        else $error("beat right after the last beat of a request");

    a_no_beat_right_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_valid)
        else $error("beat in the cycle after a request was taken");

endmodule
